// ----- rtl/core/ptpb_pkg.sv -----
// Package for the procedural tile pixel blender: codes, sizes and divide constants.
package ptpb_pkg;

	// Tile geometry and field widths.
	localparam int TILE_SIDE = 32;
	localparam int COORD_W   = 5;
	localparam int TILE_W    = 2;
	localparam int COLOR_W   = 24;
	localparam int CHAN_W    = 8;
	localparam int NUM_CHAN  = COLOR_W / CHAN_W;
	localparam int PIXEL_W   = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int SEED_W    = 32;
	localparam int STR_W     = 7;
	localparam int SCALE_W   = 2;
	localparam int FIN_W     = 3;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [SEED_W-1:0] SEED_RESET   = 32'd17;

	// Hash multipliers.
	localparam logic [31:0] HASH_K1 = 32'h9e3779b9;
	localparam logic [31:0] HASH_K2 = 32'h85ebca6b;
	localparam logic [31:0] HASH_K3 = 32'h7feb352d;

	// Blend totals and the widths that follow from them.
	localparam int FLAT_TOTAL  = 64;
	localparam int GRAD_TOTAL  = TILE_SIDE - 1;
	localparam int GRAIN_TOTAL = 63 * 64;
	localparam int STR_MAX     = 64;
	localparam int MAX_TOTAL   = GRAIN_TOTAL;
	localparam int WGT_W       = $clog2(MAX_TOTAL + 1);
	localparam int NUM_W       = $clog2(255 * MAX_TOTAL + MAX_TOTAL / 2 + 1);
	localparam int RECIP_W     = NUM_W + 1;
	localparam int PROD_W      = NUM_W + RECIP_W;

	// Divide by a constant total: q = (n * ceil(2^S / d)) >> S, exact for n < 2^NUM_W.
	localparam int SH_FLAT  = NUM_W + $clog2(FLAT_TOTAL);
	localparam int SH_GRAD  = NUM_W + $clog2(GRAD_TOTAL);
	localparam int SH_GRAIN = NUM_W + $clog2(GRAIN_TOTAL);
	localparam longint unsigned RCP_FLAT =
		((longint'(1) << SH_FLAT) + FLAT_TOTAL - 1) / FLAT_TOTAL;
	localparam longint unsigned RCP_GRAD =
		((longint'(1) << SH_GRAD) + GRAD_TOTAL - 1) / GRAD_TOTAL;
	localparam longint unsigned RCP_GRAIN =
		((longint'(1) << SH_GRAIN) + GRAIN_TOTAL - 1) / GRAIN_TOTAL;

	// Finish codes; codes above stipple act as flat.
	typedef enum logic [FIN_W-1:0] {
		FIN_FLAT     = 3'd0,
		FIN_GRADIENT = 3'd1,
		FIN_GRAIN    = 3'd2,
		FIN_STRIPES  = 3'd3,
		FIN_STIPPLE  = 3'd4
	} finish_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HASH_SEED         = 3'd0,
		REG_BLEND_STRENGTH    = 3'd1,
		REG_SCALE_SHIFT       = 3'd2,
		REG_PATTERN_DIRECTION = 3'd3,
		REG_FACE_FINISH       = 3'd4,
		REG_BORDER_FINISH     = 3'd5,
		REG_MATCH_BORDER      = 3'd6
	} reg_idx_t;

	// Which divisor a pixel blends over.
	typedef enum logic [1:0] {
		TOT_FLAT  = 2'd0,
		TOT_GRAD  = 2'd1,
		TOT_GRAIN = 2'd2
	} tot_t;

	// Load enables of the channel stages.
	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// Total value for a divisor select.
	function automatic logic [WGT_W-1:0] tot_value(input tot_t sel);
		logic [WGT_W-1:0] v;
		case (sel)
			TOT_GRAD:  v = WGT_W'(GRAD_TOTAL);
			TOT_GRAIN: v = WGT_W'(GRAIN_TOTAL);
			default:   v = WGT_W'(FLAT_TOTAL);
		endcase
		return v;
	endfunction

	// Reciprocal for a divisor select.
	function automatic logic [RECIP_W-1:0] tot_recip(input tot_t sel);
		logic [RECIP_W-1:0] r;
		case (sel)
			TOT_GRAD:  r = RECIP_W'(RCP_GRAD);
			TOT_GRAIN: r = RECIP_W'(RCP_GRAIN);
			default:   r = RECIP_W'(RCP_FLAT);
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/ptpb_if.sv -----
// Stream interfaces for pixel requests and blended color results.
interface ptpb_req_if import ptpb_pkg::*;;
	logic                valid;
	logic                ready;
	logic [TILE_W-1:0]   tile_number;
	logic [COORD_W-1:0]  pixel_x;
	logic [COORD_W-1:0]  pixel_y;
	logic [COLOR_W-1:0]  first_color;
	logic [COLOR_W-1:0]  second_color;

	modport source (output valid, tile_number, pixel_x, pixel_y, first_color, second_color,
		input ready);
	modport sink (input valid, tile_number, pixel_x, pixel_y, first_color, second_color,
		output ready);
endinterface

interface ptpb_rsp_if import ptpb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel_color;

	modport source (output valid, pixel_color, input ready);
	modport sink (input valid, pixel_color, output ready);
endinterface

// ----- rtl/core/ptpb_chan.sv -----
// One color channel: weighted sum, reciprocal multiply and quotient select over three stages.
module ptpb_chan import ptpb_pkg::*; (
	input  logic              clk,
	input  pipe_en_t          en,
	input  logic [CHAN_W-1:0] first,
	input  logic [CHAN_W-1:0] second,
	input  logic [WGT_W-1:0]  weight,
	input  tot_t              tot,
	output logic [CHAN_W-1:0] result
);

	logic [WGT_W-1:0]  tv;
	logic [NUM_W-1:0]  pa;
	logic [NUM_W-1:0]  pb;
	logic [NUM_W-1:0]  n_s4;
	tot_t              tot_s4;
	logic [PROD_W-1:0] prod_s5;
	tot_t              tot_s5;
	logic [CHAN_W-1:0] q;
	logic [CHAN_W-1:0] result_s6;

	// Weighted sum of both colors plus half the total for rounding.
	always_comb begin
		tv = tot_value(tot);
		pa = NUM_W'(first) * NUM_W'(tv - weight);
		pb = NUM_W'(second) * NUM_W'(weight);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			n_s4   <= pa + pb + NUM_W'(tv >> 1);
			tot_s4 <= tot;
		end
	end

	// Multiply by the reciprocal of the total.
	always_ff @(posedge clk) begin
		if (en.s5) begin
			prod_s5 <= PROD_W'(n_s4) * PROD_W'(tot_recip(tot_s4));
			tot_s5  <= tot_s4;
		end
	end

	// The quotient sits at a fixed offset for each total.
	always_comb begin
		case (tot_s5)
			TOT_GRAD:  q = prod_s5[SH_GRAD +: CHAN_W];
			TOT_GRAIN: q = prod_s5[SH_GRAIN +: CHAN_W];
			default:   q = prod_s5[SH_FLAT +: CHAN_W];
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			result_s6 <= q;
		end
	end

	assign result = result_s6;

endmodule

// ----- rtl/core/procedural_tile_pixel_blend_top.sv -----
// Top level of the procedural tile pixel blender.
// The block takes one pixel request per clock when the result side does not stall, and
// returns one opaque ARGB pixel for each, in order. The six register stages are: decode
// with the first hash round, the 32-bit hash multiply, the finish weight, the per-channel
// weighted sum, the reciprocal multiply that divides by the total, and the output register.
// Ready stays high while any stage is empty or the result is being taken, so bubbles are
// squeezed out during a stall. The user must write configuration only while the pipeline
// is empty; the block itself does not enforce this.
module procedural_tile_pixel_blend_top import ptpb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	ptpb_req_if.sink             req,
	ptpb_rsp_if.source           rsp
);

	// Configuration registers.
	logic [SEED_W-1:0]  hash_seed_q;
	logic [STR_W-1:0]   blend_strength_q;
	logic [SCALE_W-1:0] scale_shift_q;
	logic               pattern_direction_q;
	logic [FIN_W-1:0]   face_finish_q;
	logic [FIN_W-1:0]   border_finish_q;
	logic               match_border_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q         <= SEED_RESET;
			blend_strength_q    <= '0;
			scale_shift_q       <= '0;
			pattern_direction_q <= 1'b0;
			face_finish_q       <= '0;
			border_finish_q     <= '0;
			match_border_q      <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HASH_SEED:         hash_seed_q         <= cfg_data[SEED_W-1:0];
				REG_BLEND_STRENGTH:    blend_strength_q    <= cfg_data[STR_W-1:0];
				REG_SCALE_SHIFT:       scale_shift_q       <= cfg_data[SCALE_W-1:0];
				REG_PATTERN_DIRECTION: pattern_direction_q <= cfg_data[0];
				REG_FACE_FINISH:       face_finish_q       <= cfg_data[FIN_W-1:0];
				REG_BORDER_FINISH:     border_finish_q     <= cfg_data[FIN_W-1:0];
				REG_MATCH_BORDER:      match_border_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage valids and load enables; a stage loads when it is empty or its successor moves.
	logic     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic     en_s1, en_s2, en_s3;
	pipe_en_t en_ch;

	always_comb begin
		en_ch.s6 = !v_s6 || rsp.ready;
		en_ch.s5 = !v_s5 || en_ch.s6;
		en_ch.s4 = !v_s4 || en_ch.s5;
		en_s3    = !v_s3 || en_ch.s4;
		en_s2    = !v_s2 || en_s3;
		en_s1    = !v_s1 || en_s2;
	end

	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1)    v_s1 <= req.valid;
			if (en_s2)    v_s2 <= v_s1;
			if (en_s3)    v_s3 <= v_s2;
			if (en_ch.s4) v_s4 <= v_s3;
			if (en_ch.s5) v_s5 <= v_s4;
			if (en_ch.s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: finish select, scaled coordinates, pattern bits and the first hash round.
	logic [FIN_W-1:0]   kind_raw;
	finish_t            kind;
	logic [COORD_W-1:0] xs, ys, coord;
	logic [STR_W-1:0]   str;
	logic [WGT_W-1:0]   grad_w;
	logic [31:0]        h0;

	always_comb begin
		kind_raw = (!req.tile_number[1] || match_border_q) ? face_finish_q : border_finish_q;
		case (finish_t'(kind_raw))
			FIN_GRADIENT: kind = FIN_GRADIENT;
			FIN_GRAIN:    kind = FIN_GRAIN;
			FIN_STRIPES:  kind = FIN_STRIPES;
			FIN_STIPPLE:  kind = FIN_STIPPLE;
			default:      kind = FIN_FLAT;
		endcase
		xs    = req.pixel_x >> scale_shift_q;
		ys    = req.pixel_y >> scale_shift_q;
		str   = (blend_strength_q > STR_W'(STR_MAX)) ? STR_W'(STR_MAX) : blend_strength_q;
		coord = pattern_direction_q ? req.pixel_x : req.pixel_y;
		grad_w = (WGT_W'(coord) > WGT_W'(GRAD_TOTAL)) ? WGT_W'(GRAD_TOTAL) : WGT_W'(coord);
		h0 = hash_seed_q ^ 32'(xs * HASH_K1) ^ 32'(ys * HASH_K2);
	end

	finish_t            kind_s1;
	logic [WGT_W-1:0]   grad_w_s1;
	logic               stripe_s1, stipple_s1;
	logic [STR_W-1:0]   str_s1;
	logic [COLOR_W-1:0] c1_s1, c2_s1;
	logic [31:0]        hf_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1    <= kind;
			grad_w_s1  <= grad_w;
			stripe_s1  <= pattern_direction_q ? xs[0] : ys[0];
			stipple_s1 <= !xs[0] && !ys[0];
			str_s1     <= str;
			c1_s1      <= req.first_color;
			c2_s1      <= req.second_color;
			hf_s1      <= h0 ^ (h0 >> 16);
		end
	end

	// Stage 2: hash multiply.
	finish_t            kind_s2;
	logic [WGT_W-1:0]   grad_w_s2;
	logic               stripe_s2, stipple_s2;
	logic [STR_W-1:0]   str_s2;
	logic [COLOR_W-1:0] c1_s2, c2_s2;
	logic [31:0]        h2_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			kind_s2    <= kind_s1;
			grad_w_s2  <= grad_w_s1;
			stripe_s2  <= stripe_s1;
			stipple_s2 <= stipple_s1;
			str_s2     <= str_s1;
			c1_s2      <= c1_s1;
			c2_s2      <= c2_s1;
			h2_s2      <= hf_s1 * HASH_K3;
		end
	end

	// Stage 3: final hash fold and the weight and total of the finish.
	logic [31:0]      h3;
	logic [WGT_W-1:0] weight;
	tot_t             tot;

	always_comb begin
		h3 = h2_s2 ^ (h2_s2 >> 15);
		case (kind_s2)
			FIN_GRADIENT: begin
				weight = grad_w_s2;
				tot    = TOT_GRAD;
			end
			FIN_GRAIN: begin
				weight = WGT_W'(h3[5:0]) * WGT_W'(str_s2);
				tot    = TOT_GRAIN;
			end
			FIN_STRIPES: begin
				weight = stripe_s2 ? WGT_W'(str_s2) : '0;
				tot    = TOT_FLAT;
			end
			FIN_STIPPLE: begin
				weight = stipple_s2 ? WGT_W'(str_s2) : '0;
				tot    = TOT_FLAT;
			end
			default: begin
				weight = '0;
				tot    = TOT_FLAT;
			end
		endcase
	end

	logic [WGT_W-1:0]   weight_s3;
	tot_t               tot_s3;
	logic [COLOR_W-1:0] c1_s3, c2_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			weight_s3 <= weight;
			tot_s3    <= tot;
			c1_s3     <= c1_s2;
			c2_s3     <= c2_s2;
		end
	end

	// Stages 4 to 6: one blend unit per channel.
	logic [COLOR_W-1:0] rgb;

	for (genvar i = 0; i < NUM_CHAN; i++) begin : g_chan
		ptpb_chan u_chan (
			.clk    (clk),
			.en     (en_ch),
			.first  (c1_s3[i*CHAN_W +: CHAN_W]),
			.second (c2_s3[i*CHAN_W +: CHAN_W]),
			.weight (weight_s3),
			.tot    (tot_s3),
			.result (rgb[i*CHAN_W +: CHAN_W])
		);
	end

	assign rsp.valid       = v_s6;
	assign rsp.pixel_color = {ALPHA_OPAQUE, rgb};

	// An accepted request always occupies the first stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> v_s1)
		else $error("accepted request did not enter stage 1");

	// The finish weight never exceeds its total.
	a_weight_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (weight_s3 <= tot_value(tot_s3)))
		else $error("blend weight above total");

	// A held stage keeps its item and hash value.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en_s3) |=> (v_s2 && $stable(h2_s2) && $stable(kind_s2)))
		else $error("stage 2 item lost during stall");

	// A stage 5 item is held while the output register stalls.
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !en_ch.s6) |=> (v_s5 && v_s6))
		else $error("stage 5 item lost while the output stalls");

endmodule

// ----- tb/procedural_tile_pixel_blend_top_test.sv -----
// Self-checking testbench for the tile pixel blender: a directed table, then random phases.
`timescale 1ns / 1ps
module procedural_tile_pixel_blend_top_test;
	import ptpb_pkg::*;

	// The pipeline is six stages deep; a little margin covers the drain.
	localparam int LATENCY     = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 112;

	// Index past the register list and a finish code past stipple.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam logic [FIN_W-1:0]     FIN_SPARE = 3'd7;

	typedef struct packed {
		logic [TILE_W-1:0]  tile;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] c1;
		logic [COLOR_W-1:0] c2;
	} pixel_req_t;

	// A typed color, or a request to ask the predictor.
	typedef struct {
		bit                 known;
		logic [PIXEL_W-1:0] color;
	} preset_color_t;

	// One row of the directed table: a register write or a pixel request.
	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		pixel_req_t           pix;
		bit                   known;
		logic [PIXEL_W-1:0]   color;
	} table_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ptpb_req_if req ();
	ptpb_rsp_if rsp ();

	procedural_tile_pixel_blend_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	always #4 clk = ~clk;

	// Shadow copy of the configuration registers.
	logic [SEED_W-1:0]  seed_q;
	logic [STR_W-1:0]   strength_q;
	logic [SCALE_W-1:0] scale_q;
	logic               dir_q;
	logic [FIN_W-1:0]   face_q;
	logic [FIN_W-1:0]   border_q;
	logic               match_q;

	preset_color_t      preset_colors[$];
	logic [PIXEL_W-1:0] expected_colors[$];
	table_row_t         table_rows[$];
	int                 mismatches  = 0;
	int                 quiet_cycles = 0;
	bit                 steady = 1'b0;

	// Blended ARGB color of one pixel under the current configuration.
	function automatic logic [PIXEL_W-1:0] blend_pixel(pixel_req_t p);
		logic [FIN_W-1:0]   fin;
		logic [COORD_W-1:0] xs;
		logic [COORD_W-1:0] ys;
		logic [STR_W-1:0]   str;
		logic [31:0]        h;
		int unsigned        wgt;
		int unsigned        tot;
		int unsigned        a;
		int unsigned        b;
		int unsigned        mix;
		int                 ch;
		logic [PIXEL_W-1:0] color;
		fin = (p.tile < 2 || match_q) ? face_q : border_q;
		xs = p.x >> scale_q;
		ys = p.y >> scale_q;
		str = (strength_q > STR_MAX) ? STR_W'(STR_MAX) : strength_q;
		h = seed_q ^ (32'(xs) * HASH_K1) ^ (32'(ys) * HASH_K2);
		h = h ^ (h >> 16);
		h = h * HASH_K3;
		h = h ^ (h >> 15);
		wgt = 0;
		tot = FLAT_TOTAL;
		case (fin)
			FIN_GRADIENT: begin
				tot = GRAD_TOTAL;
				wgt = dir_q ? 32'(p.x) : 32'(p.y);
				if (wgt > tot)
					wgt = tot;
			end
			FIN_GRAIN: begin
				tot = GRAIN_TOTAL;
				wgt = 32'(h[5:0]) * 32'(str);
			end
			FIN_STRIPES: wgt = (dir_q ? xs[0] : ys[0]) ? 32'(str) : 32'd0;
			FIN_STIPPLE: wgt = (!xs[0] && !ys[0]) ? 32'(str) : 32'd0;
			default: ;
		endcase
		color[PIXEL_W-1:COLOR_W] = ALPHA_OPAQUE;
		for (ch = 0; ch < NUM_CHAN; ch++) begin
			a = 32'(p.c1[ch*CHAN_W +: CHAN_W]);
			b = 32'(p.c2[ch*CHAN_W +: CHAN_W]);
			mix = (a * (tot - wgt) + b * wgt + tot / 2) / tot;
			color[ch*CHAN_W +: CHAN_W] = mix[CHAN_W-1:0];
		end
		return color;
	endfunction

	task automatic report_mismatch(string what, logic [PIXEL_W-1:0] want,
			logic [PIXEL_W-1:0] got);
		mismatches++;
		$display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
	endtask

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		table_rows.push_back('{1'b1, idx, data, '0, 1'b0, '0});
	endfunction

	function automatic void add_pixel(logic [TILE_W-1:0] tile, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COLOR_W-1:0] c1, logic [COLOR_W-1:0] c2,
			bit known, logic [PIXEL_W-1:0] color);
		table_rows.push_back('{1'b0, '0, '0, '{tile, x, y, c1, c2}, known, color});
	endfunction

	// Write one register; the caller lowers the write enable after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_HASH_SEED:         seed_q = data;
			REG_BLEND_STRENGTH:    strength_q = data[STR_W-1:0];
			REG_SCALE_SHIFT:       scale_q = data[SCALE_W-1:0];
			REG_PATTERN_DIRECTION: dir_q = data[0];
			REG_FACE_FINISH:       face_q = data[FIN_W-1:0];
			REG_BORDER_FINISH:     border_q = data[FIN_W-1:0];
			REG_MATCH_BORDER:      match_q = data[0];
			default: ;
		endcase
	endtask

	// Present one pixel request after a random gap (none in steady phases) and hold it until it is taken.
	task automatic send_pixel(pixel_req_t p, bit known, logic [PIXEL_W-1:0] color);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		preset_colors.push_back('{known, color});
		req.valid <= 1'b1;
		req.tile_number <= p.tile;
		req.pixel_x <= p.x;
		req.pixel_y <= p.y;
		req.first_color <= p.c1;
		req.second_color <= p.c2;
		do @(posedge clk); while (!req.ready);
	endtask

	// Stop requesting, wait for every outstanding color, then let the pipeline settle.
	task automatic drain_pipe();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_colors.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Result side: a random stall before each result, none in steady phases.
	initial begin
		int stall;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// Record expectations for taken requests, compare taken results, and watch for a hang.
	always @(posedge clk) begin
		preset_color_t      preset;
		pixel_req_t         p;
		logic [PIXEL_W-1:0] want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				preset = preset_colors.pop_front();
				p = '{req.tile_number, req.pixel_x, req.pixel_y, req.first_color,
					req.second_color};
				expected_colors.push_back(preset.known ? preset.color : blend_pixel(p));
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_colors.size() == 0) begin
					report_mismatch("pixel_color with no request outstanding", '0,
						rsp.pixel_color);
				end else begin
					want = expected_colors.pop_front();
					if (rsp.pixel_color !== want)
						report_mismatch("pixel_color", want, rsp.pixel_color);
				end
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then random phases under changing settings.
	initial begin
		pixel_req_t  p;
		logic [31:0] junk;
		bit          writing;
		int          k;
		int          n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.tile_number = '0;
		req.pixel_x = '0;
		req.pixel_y = '0;
		req.first_color = '0;
		req.second_color = '0;
		seed_q = SEED_RESET;
		strength_q = '0;
		scale_q = '0;
		dir_q = 1'b0;
		face_q = FIN_FLAT;
		border_q = FIN_FLAT;
		match_q = 1'b0;
		writing = 1'b0;

		// Reset settings: every tile is flat, so the first color comes straight through.
		add_pixel(2'd0, 5'd0, 5'd0, 24'h000000, 24'hffffff, 1, 32'hff000000);
		add_pixel(2'd3, 5'd31, 5'd31, 24'hffffff, 24'h000000, 1, 32'hffffffff);
		add_pixel(2'd1, 5'd31, 5'd0, 24'h123456, 24'habcdef, 1, 32'hff123456);
		add_pixel(2'd2, 5'd0, 5'd31, 24'ha5a5a5, 24'h5a5a5a, 1, 32'hffa5a5a5);
		// Gradient faces along y; borders stay flat.
		add_write(REG_FACE_FINISH, FIN_GRADIENT);
		add_pixel(2'd0, 5'd5, 5'd31, 24'h000000, 24'hffffff, 1, 32'hffffffff);
		add_pixel(2'd1, 5'd31, 5'd0, 24'h000000, 24'hffffff, 1, 32'hff000000);
		add_pixel(2'd2, 5'd0, 5'd31, 24'h102030, 24'hffffff, 1, 32'hff102030);
		add_pixel(2'd0, 5'd7, 5'd13, 24'h3c7f01, 24'hc280fe, 0, '0);
		// Borders follow the face finish; gradient along x.
		add_write(REG_MATCH_BORDER, 1);
		add_write(REG_PATTERN_DIRECTION, 1);
		add_pixel(2'd3, 5'd31, 5'd2, 24'hffffff, 24'h000000, 1, 32'hff000000);
		add_pixel(2'd2, 5'd10, 5'd10, 24'h55aa00, 24'h00aa55, 0, '0);
		// Grain with an oversized strength that saturates, the widest scale, all-ones seed.
		add_write(REG_BLEND_STRENGTH, 127);
		add_write(REG_FACE_FINISH, FIN_GRAIN);
		add_write(REG_HASH_SEED, 32'hffffffff);
		add_write(REG_SCALE_SHIFT, 3);
		add_pixel(2'd0, 5'd31, 5'd31, 24'h00ff00, 24'hff00ff, 0, '0);
		add_pixel(2'd3, 5'd0, 5'd0, 24'h000000, 24'hffffff, 0, '0);
		// Stripes along y at full strength.
		add_write(REG_FACE_FINISH, FIN_STRIPES);
		add_write(REG_PATTERN_DIRECTION, 0);
		add_write(REG_SCALE_SHIFT, 0);
		add_write(REG_BLEND_STRENGTH, STR_MAX);
		add_pixel(2'd0, 5'd0, 5'd1, 24'h000000, 24'hffffff, 1, 32'hffffffff);
		add_pixel(2'd0, 5'd0, 5'd2, 24'h000000, 24'hffffff, 1, 32'hff000000);
		// Stipple: only even-even cells take the second color.
		add_write(REG_FACE_FINISH, FIN_STIPPLE);
		add_pixel(2'd1, 5'd2, 5'd4, 24'h000000, 24'hffffff, 1, 32'hffffffff);
		add_pixel(2'd1, 5'd3, 5'd4, 24'h000000, 24'hffffff, 1, 32'hff000000);
		// An unused finish code acts as flat.
		add_write(REG_FACE_FINISH, FIN_SPARE);
		add_pixel(2'd0, 5'd1, 5'd1, 24'habcdef, 24'h000000, 1, 32'hffabcdef);
		// A write past the register list changes nothing; borders get their own gradient.
		add_write(REG_SPARE, 32'hffffffff);
		add_write(REG_MATCH_BORDER, 0);
		add_write(REG_BORDER_FINISH, FIN_GRADIENT);
		add_pixel(2'd3, 5'd0, 5'd31, 24'h000000, 24'hffffff, 1, 32'hffffffff);
		add_pixel(2'd0, 5'd31, 5'd31, 24'h000000, 24'hffffff, 1, 32'hff000000);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table.
		foreach (table_rows[i]) begin
			if (table_rows[i].is_write) begin
				if (!writing)
					drain_pipe();
				writing = 1'b1;
				write_reg(table_rows[i].idx, table_rows[i].data);
			end else begin
				if (writing)
					cfg_we <= 1'b0;
				writing = 1'b0;
				send_pixel(table_rows[i].pix, table_rows[i].known, table_rows[i].color);
			end
		end

		// Random phases; every third one runs with no gaps on either side.
		for (k = 0; k < NUM_PHASES; k++) begin
			drain_pipe();
			steady = (k % 3 == 2);
			junk = (k % 2) ? $urandom : 32'h0;
			write_reg(REG_HASH_SEED, (k == 0) ? 32'h0 : (k == 1) ? 32'hffffffff : $urandom);
			case (k % 4)
				0: write_reg(REG_BLEND_STRENGTH, (junk << STR_W) | 32'd0);
				1: write_reg(REG_BLEND_STRENGTH, (junk << STR_W) | 32'(STR_MAX));
				2: write_reg(REG_BLEND_STRENGTH, (junk << STR_W) | 32'd127);
				default: write_reg(REG_BLEND_STRENGTH, (junk << STR_W) | $urandom_range(0, 127));
			endcase
			write_reg(REG_SCALE_SHIFT, (junk << SCALE_W) | 32'(k % 4));
			write_reg(REG_PATTERN_DIRECTION, (junk << 1) | 32'(k % 2));
			write_reg(REG_FACE_FINISH, (junk << FIN_W) | 32'(k % 8));
			write_reg(REG_BORDER_FINISH, (junk << FIN_W) | 32'((k + 3) % 8));
			write_reg(REG_MATCH_BORDER, (junk << 1) | 32'((k / 3) % 2));
			if (k == 5)
				write_reg(REG_SPARE, $urandom);
			cfg_we <= 1'b0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				p.tile = TILE_W'($urandom_range(0, 3));
				p.x = COORD_W'($urandom_range(0, 31));
				p.y = COORD_W'($urandom_range(0, 31));
				case ($urandom_range(0, 9))
					0: p.c1 = '0;
					1: p.c1 = '1;
					default: p.c1 = COLOR_W'($urandom);
				endcase
				case ($urandom_range(0, 9))
					0: p.c2 = '0;
					1: p.c2 = '1;
					default: p.c2 = COLOR_W'($urandom);
				endcase
				send_pixel(p, 1'b0, '0);
			end
		end

		drain_pipe();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ptpb_pkg.sv
rtl/core/ptpb_if.sv
rtl/core/ptpb_chan.sv
rtl/core/procedural_tile_pixel_blend_top.sv
tb/procedural_tile_pixel_blend_top_test.sv
